// File: rtl/core/cbc_pkg.sv
// Package for the cartridge bank controller: access kind codes, fixed
// bank sizes and the decoded access struct. No dependencies.
`timescale 1ns / 1ps

package cbc_pkg;

    // Number of external RAM banks (1 to 4).
    localparam int RAM_BANKS_DEFAULT = 4;

    // Sizes fixed by the cartridge bus map.
    localparam int RAM_BANK_BYTES = 8192;
    localparam int ROM_BANK_BYTES = 16384;
    localparam int RAM_OFFSET_W   = $clog2(RAM_BANK_BYTES);
    localparam int ROM_OFFSET_W   = $clog2(ROM_BANK_BYTES);
    localparam int ROM_BANK_W     = 7;
    localparam int RAM_SEL_W      = 2;
    localparam int ROM_ADDR_W     = ROM_BANK_W + ROM_OFFSET_W;
    localparam int ADDR_W         = 16;
    localparam int DATA_W         = 8;

    // Bit fields of the bus map.
    localparam logic [4:0] ROM_LOW_MASK = 5'h1F;

    typedef enum logic [1:0] {
        KIND_RAM      = 2'd0,
        KIND_ROM      = 2'd1,
        KIND_BASE     = 2'd2,
        KIND_INTERNAL = 2'd3
    } cbc_kind_t;

    // Decoded access handed from the bank register file to the top level.
    typedef struct packed {
        cbc_kind_t kind;
        logic      ram_re;
        logic      ram_we;
    } cbc_access_t;

endpackage

// File: rtl/core/cbc_if.sv
// Valid/ready channel interfaces for bus access items and result items.
// Depends on cbc_pkg for field widths.
`timescale 1ns / 1ps

interface cbc_req_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [cbc_pkg::ADDR_W-1:0]  address;
    logic [cbc_pkg::DATA_W-1:0]  write_data;
    logic                        ext_ram_enabled;

    modport source (output valid, output operation, output address,
                    output write_data, output ext_ram_enabled, input ready);
    modport sink   (input valid, input operation, input address,
                    input write_data, input ext_ram_enabled, output ready);
endinterface

interface cbc_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      access_kind;
    logic [cbc_pkg::DATA_W-1:0]      read_data;
    logic [cbc_pkg::ROM_ADDR_W-1:0]  rom_address;

    modport source (output valid, output access_kind, output read_data,
                    output rom_address, input ready);
    modport sink   (input valid, input access_kind, input read_data,
                    input rom_address, output ready);
endinterface

// File: rtl/core/cartridge_bank_controller.sv
// Top level of the cartridge bank controller.
// Depends on cbc_pkg, cbc_if, cbc_bank_regs and cbc_ram.
`timescale 1ns / 1ps

// Takes one CPU bus access item per cycle while the result side is not
// stalled and returns one result item for each, in order. On acceptance it
// decodes the address, updates the bank registers and issues the RAM store
// access; the item then moves through a pending register into the output
// register, which captures the registered RAM read data. The RAM store has
// no reset: a read of an entry that was never written returns undefined data.
// The bank selects reset to ROM bank one, RAM bank zero and ROM banking mode.
module cartridge_bank_controller #(
    parameter int RAM_BANKS = cbc_pkg::RAM_BANKS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    cbc_req_if.sink    req,
    cbc_rsp_if.source  rsp
);

    localparam int IDX_W = $clog2(RAM_BANKS * cbc_pkg::RAM_BANK_BYTES);

    cbc_pkg::cbc_access_t             acc;
    logic [cbc_pkg::ROM_ADDR_W-1:0]   dec_rom_address;
    logic [IDX_W-1:0]                 ram_index;
    logic [cbc_pkg::DATA_W-1:0]       ram_rdata;
    logic                             accept, out_free;

    logic                             pend_valid_reg, pend_valid_next;
    cbc_pkg::cbc_kind_t               pend_kind_reg;
    logic [cbc_pkg::ROM_ADDR_W-1:0]   pend_rom_reg;

    logic                             out_valid_reg, out_valid_next;
    cbc_pkg::cbc_kind_t               out_kind_reg;
    logic [cbc_pkg::ROM_ADDR_W-1:0]   out_rom_reg;
    logic [cbc_pkg::DATA_W-1:0]       out_data_reg;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = !pend_valid_reg || out_free;
    assign accept    = req.valid && req.ready;

    cbc_bank_regs #(.RAM_BANKS(RAM_BANKS)) u_regs (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .operation       (req.operation),
        .address         (req.address),
        .write_data      (req.write_data),
        .ext_ram_enabled (req.ext_ram_enabled),
        .acc             (acc),
        .rom_address     (dec_rom_address),
        .ram_index       (ram_index)
    );

    // The read data register only moves on a new RAM read, so it holds
    // while the pending item waits for the output register.
    cbc_ram #(.RAM_BANKS(RAM_BANKS)) u_ram (
        .clk   (clk),
        .we    (accept && acc.ram_we),
        .re    (accept && acc.ram_re),
        .index (ram_index),
        .wdata (req.write_data),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (accept)
            pend_valid_next = 1'b1;
        else if (out_free)
            pend_valid_next = 1'b0;
        else
            pend_valid_next = pend_valid_reg;
        out_valid_next = out_free ? pend_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_kind_reg <= acc.kind;
            pend_rom_reg  <= dec_rom_address;
        end
        if (out_free && pend_valid_reg)
        begin
            out_kind_reg <= pend_kind_reg;
            out_rom_reg  <= pend_rom_reg;
            out_data_reg <= (pend_kind_reg == cbc_pkg::KIND_RAM) ? ram_rdata : '0;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.access_kind = out_kind_reg;
    assign rsp.read_data   = out_data_reg;
    assign rsp.rom_address = out_rom_reg;

endmodule

// File: rtl/core/cbc_bank_regs.sv
// Bank select registers and bus address decode of the cartridge bank
// controller. Depends on cbc_pkg.
`timescale 1ns / 1ps

module cbc_bank_regs #(
    parameter int RAM_BANKS = cbc_pkg::RAM_BANKS_DEFAULT,
    localparam int IDX_W = $clog2(RAM_BANKS * cbc_pkg::RAM_BANK_BYTES)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic                              operation,
    input  logic [cbc_pkg::ADDR_W-1:0]        address,
    input  logic [cbc_pkg::DATA_W-1:0]        write_data,
    input  logic                              ext_ram_enabled,
    output cbc_pkg::cbc_access_t              acc,
    output logic [cbc_pkg::ROM_ADDR_W-1:0]    rom_address,
    output logic [IDX_W-1:0]                  ram_index
);

    localparam logic [cbc_pkg::RAM_SEL_W-1:0] BANKS_C = cbc_pkg::RAM_SEL_W'(RAM_BANKS);

    logic [cbc_pkg::ROM_BANK_W-1:0] rom_bank_reg, rom_bank_next;
    logic [cbc_pkg::RAM_SEL_W-1:0]  ram_bank_reg, ram_bank_next;
    logic                           mode_reg, mode_next;

    logic                           rom_win, ram_win, w_low, w_upper, w_mode;
    logic [cbc_pkg::DATA_W-1:0]     low_value;
    logic [cbc_pkg::RAM_SEL_W-1:0]  bank_wrapped;
    logic [cbc_pkg::RAM_SEL_W+cbc_pkg::RAM_OFFSET_W-1:0] full_index;

    assign rom_win = (address[15:14] == 2'b01);
    assign ram_win = (address[15:13] == 3'b101);
    assign w_low   = (address[15:13] == 3'b001);
    assign w_upper = (address[15:13] == 3'b010);
    assign w_mode  = (address[15:13] == 3'b011);

    // The select value wraps to the fitted banks; it never reaches twice
    // the bank count once there are two or more banks.
    always_comb
    begin
        if (RAM_BANKS == 1)
            bank_wrapped = '0;
        else if (ram_bank_reg >= BANKS_C && RAM_BANKS < 4)
            bank_wrapped = ram_bank_reg - BANKS_C;
        else
            bank_wrapped = ram_bank_reg;
    end

    assign full_index  = {bank_wrapped, address[cbc_pkg::RAM_OFFSET_W-1:0]};
    assign ram_index   = full_index[IDX_W-1:0];

    // A zero byte selects bank one; the test looks at the whole byte.
    assign low_value = (write_data == '0) ? cbc_pkg::DATA_W'(1) : write_data;

    always_comb
    begin
        acc.kind    = cbc_pkg::KIND_BASE;
        acc.ram_re  = 1'b0;
        acc.ram_we  = 1'b0;
        rom_address = '0;
        if (!operation)
        begin
            if (rom_win)
            begin
                acc.kind    = cbc_pkg::KIND_ROM;
                rom_address = {rom_bank_reg, address[cbc_pkg::ROM_OFFSET_W-1:0]};
            end
            else if (ram_win)
            begin
                acc.kind   = cbc_pkg::KIND_RAM;
                acc.ram_re = 1'b1;
            end
        end
        else
        begin
            if (w_low || w_upper || w_mode)
                acc.kind = cbc_pkg::KIND_INTERNAL;
            else if (ram_win && ext_ram_enabled)
            begin
                acc.kind   = cbc_pkg::KIND_INTERNAL;
                acc.ram_we = 1'b1;
            end
        end
    end

    always_comb
    begin
        rom_bank_next = rom_bank_reg;
        ram_bank_next = ram_bank_reg;
        mode_next     = mode_reg;
        if (accept && operation)
        begin
            if (w_low)
                rom_bank_next = {rom_bank_reg[6:5], low_value[4:0] & cbc_pkg::ROM_LOW_MASK};
            else if (w_upper)
            begin
                if (!mode_reg)
                    rom_bank_next = {write_data[1:0], rom_bank_reg[4:0]};
                else
                    ram_bank_next = write_data[1:0];
            end
            else if (w_mode)
                mode_next = write_data[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_reg <= cbc_pkg::ROM_BANK_W'(1);
            ram_bank_reg <= '0;
            mode_reg     <= 1'b0;
        end
        else
        begin
            rom_bank_reg <= rom_bank_next;
            ram_bank_reg <= ram_bank_next;
            mode_reg     <= mode_next;
        end
    end

endmodule

// File: rtl/core/cbc_ram.sv
// Banked external RAM store: one synchronous port, registered read data.
// Depends on cbc_pkg.
`timescale 1ns / 1ps

module cbc_ram #(
    parameter int RAM_BANKS = cbc_pkg::RAM_BANKS_DEFAULT,
    localparam int DEPTH = RAM_BANKS * cbc_pkg::RAM_BANK_BYTES,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic                          re,
    input  logic [IDX_W-1:0]              index,
    input  logic [cbc_pkg::DATA_W-1:0]    wdata,
    output logic [cbc_pkg::DATA_W-1:0]    rdata
);

    logic [cbc_pkg::DATA_W-1:0] mem [DEPTH];
    logic [cbc_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[index] <= wdata;
        if (re)
            rdata_reg <= mem[index];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/cbc_checker.sv
// Port-level checks for the cartridge bank controller, bound to its top.
// Depends on cbc_pkg and cartridge_bank_controller.
`timescale 1ns / 1ps

module cbc_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rsp_valid,
    input  logic                              rsp_ready,
    input  logic [1:0]                        access_kind,
    input  logic [cbc_pkg::DATA_W-1:0]        read_data,
    input  logic [cbc_pkg::ROM_ADDR_W-1:0]    rom_address
);

    // A result item that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result item dropped while stalled");

    // A stalled result item keeps its fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            $stable(access_kind) && $stable(read_data) && $stable(rom_address))
        else $error("stalled result item changed");

    // Only banked ROM fetches carry a ROM address.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && access_kind != cbc_pkg::KIND_ROM |-> rom_address == '0)
        else $error("ROM address on a non-ROM result");

    // Only RAM reads carry data.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && access_kind != cbc_pkg::KIND_RAM |-> read_data == '0)
        else $error("read data on a non-RAM result");

endmodule

bind cartridge_bank_controller cbc_checker u_cbc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .access_kind (rsp.access_kind),
    .read_data   (rsp.read_data),
    .rom_address (rsp.rom_address)
);

// File: dv/cartridge_bank_controller_test.sv
// Self-checking testbench for the cartridge bank controller: directed and random bus
// access items, a bank register and RAM image predictor, and an in-order response check.
// Depends on cbc_pkg, cbc_if and the cartridge_bank_controller RTL.
`timescale 1ns / 1ps

module cartridge_bank_controller_test;

    import cbc_pkg::*;

    localparam int RAM_BANKS     = RAM_BANKS_DEFAULT;
    localparam int STORE_BYTES   = RAM_BANKS * RAM_BANK_BYTES;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_OFF_AT   = 400;
    localparam int HOLD_OFF_LEN  = 300;
    localparam int QUIET_FROM    = 700;
    localparam int QUIET_TO      = 900;
    localparam int IDLE_PERCENT  = 7;
    localparam int TAIL_CYCLES   = 8;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;
    localparam logic MODE_ROM = 1'b0;

    localparam logic [ADDR_W-1:0] ROM_LOW_LO = 16'h2000;
    localparam logic [ADDR_W-1:0] ROM_LOW_HI = 16'h3FFF;
    localparam logic [ADDR_W-1:0] ROM_WIN_LO = 16'h4000;
    localparam logic [ADDR_W-1:0] ROM_WIN_HI = 16'h7FFF;
    localparam logic [ADDR_W-1:0] BANK_HI_LO = 16'h4000;
    localparam logic [ADDR_W-1:0] BANK_HI_HI = 16'h5FFF;
    localparam logic [ADDR_W-1:0] MODE_LO    = 16'h6000;
    localparam logic [ADDR_W-1:0] MODE_HI    = 16'h7FFF;
    localparam logic [ADDR_W-1:0] RAM_WIN_LO = 16'hA000;
    localparam logic [ADDR_W-1:0] RAM_WIN_HI = 16'hBFFF;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              en;
    } bus_access_t;

    typedef struct packed {
        logic [ROM_BANK_W-1:0] rom_bank;
        logic [RAM_SEL_W-1:0]  ram_bank;
        logic                  mode;
    } bank_regs_t;

    typedef struct packed {
        cbc_kind_t             kind;
        logic [DATA_W-1:0]     rdata;
        logic [ROM_ADDR_W-1:0] raddr;
    } bus_response_t;

    logic clk = 1'b1;
    logic rst_n = 1'b0;

    cbc_req_if req_ch();
    cbc_rsp_if rsp_ch();

    cartridge_bank_controller #(.RAM_BANKS(RAM_BANKS)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    bus_access_t   pending_accesses[$];
    bus_response_t expected_responses[$];

    // Bank registers as seen by the stimulus planner and by the response predictor.
    bank_regs_t  plan_regs;
    bank_regs_t  dut_regs;
    logic [DATA_W-1:0] ram_image [STORE_BYTES];
    bit          ram_written [STORE_BYTES];
    int unsigned written_offsets [RAM_BANKS][$];

    int   accepted_accesses = 0;
    int   mismatches = 0;
    int   stall_cycles = 0;
    logic req_fired = 1'b0;
    int   hold_off_left = 0;
    bit   hold_off_done = 1'b0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Decodes one access against the bank registers and applies its register update.
    function automatic cbc_kind_t decode_access(input bus_access_t acc, inout bank_regs_t regs,
            output logic [ROM_ADDR_W-1:0] rom_addr, output int unsigned ram_idx,
            output logic ram_wr);
        logic [DATA_W-1:0] low_val;
        logic              in_ram;
        cbc_kind_t         kind;
        kind = KIND_BASE;
        rom_addr = '0;
        ram_wr = 1'b0;
        in_ram = acc.addr >= RAM_WIN_LO && acc.addr <= RAM_WIN_HI;
        ram_idx = (int'(regs.ram_bank) % RAM_BANKS) * RAM_BANK_BYTES
                  + int'(acc.addr[RAM_OFFSET_W-1:0]);
        if (acc.op == OP_READ)
        begin
            if (acc.addr >= ROM_WIN_LO && acc.addr <= ROM_WIN_HI)
            begin
                kind = KIND_ROM;
                rom_addr = ROM_ADDR_W'(int'(regs.rom_bank) * ROM_BANK_BYTES
                                       + int'(acc.addr - ROM_WIN_LO));
            end
            else if (in_ram)
                kind = KIND_RAM;
        end
        else
        begin
            if (acc.addr >= ROM_LOW_LO && acc.addr <= ROM_LOW_HI)
            begin
                // The zero test looks at the whole byte, so 0x20 still clears the low bits.
                low_val = (acc.data == '0) ? 8'd1 : acc.data;
                regs.rom_bank[4:0] = low_val[4:0] & ROM_LOW_MASK;
                kind = KIND_INTERNAL;
            end
            else if (acc.addr >= BANK_HI_LO && acc.addr <= BANK_HI_HI)
            begin
                if (regs.mode == MODE_ROM)
                    regs.rom_bank[6:5] = acc.data[1:0];
                else
                    regs.ram_bank = acc.data[1:0];
                kind = KIND_INTERNAL;
            end
            else if (acc.addr >= MODE_LO && acc.addr <= MODE_HI)
            begin
                regs.mode = acc.data[0];
                kind = KIND_INTERNAL;
            end
            else if (in_ram && acc.en)
            begin
                ram_wr = 1'b1;
                kind = KIND_INTERNAL;
            end
        end
        return kind;
    endfunction

    // Queues one access; a read of a never written RAM entry becomes a write that fills it.
    task automatic add_access(input logic op, input logic [ADDR_W-1:0] addr,
            input logic [DATA_W-1:0] data, input logic en);
        bus_access_t           acc;
        bank_regs_t            next_regs;
        logic [ROM_ADDR_W-1:0] rom_addr;
        int unsigned           idx;
        logic                  wr;
        acc = '{op: op, addr: addr, data: data, en: en};
        next_regs = plan_regs;
        if (decode_access(acc, next_regs, rom_addr, idx, wr) == KIND_RAM && !ram_written[idx])
        begin
            acc.op = OP_WRITE;
            acc.en = 1'b1;
            next_regs = plan_regs;
            void'(decode_access(acc, next_regs, rom_addr, idx, wr));
        end
        plan_regs = next_regs;
        if (wr && !ram_written[idx])
        begin
            ram_written[idx] = 1'b1;
            written_offsets[idx / RAM_BANK_BYTES].push_back(idx % RAM_BANK_BYTES);
        end
        pending_accesses.push_back(acc);
    endtask

    task automatic add_random_access();
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              en;
        int                pick;
        int                bank;
        int                sel;
        op = 1'($urandom_range(1));
        addr = 16'($urandom_range(16'hFFFF));
        data = 8'($urandom_range(255));
        en = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 20)
        begin
            op = OP_READ;
            addr = ROM_WIN_LO + 16'($urandom_range(16'h3FFF));
        end
        else if (pick < 35)
        begin
            op = OP_READ;
            bank = int'(plan_regs.ram_bank) % RAM_BANKS;
            sel = written_offsets[bank].size();
            if (sel != 0)
                addr = RAM_WIN_LO + 16'(written_offsets[bank][$urandom_range(sel - 1)]);
            else
                addr = RAM_WIN_LO + 16'($urandom_range(RAM_BANK_BYTES - 1));
        end
        else if (pick < 50)
        begin
            op = OP_WRITE;
            en = $urandom_range(99) >= 20;
            // A small pool of offsets makes later reads hit what was stored.
            if ($urandom_range(1))
                addr = RAM_WIN_LO + 16'($urandom_range(31));
            else
                addr = RAM_WIN_LO + 16'($urandom_range(RAM_BANK_BYTES - 1));
        end
        else if (pick < 60)
        begin
            op = OP_WRITE;
            addr = ROM_LOW_LO + 16'($urandom_range(16'h1FFF));
            sel = $urandom_range(9);
            if (sel == 0)
                data = '0;
            else if (sel == 1)
                data = {3'($urandom_range(7)), 5'd0};
        end
        else if (pick < 68)
        begin
            op = OP_WRITE;
            addr = BANK_HI_LO + 16'($urandom_range(16'h1FFF));
        end
        else if (pick < 73)
        begin
            op = OP_WRITE;
            addr = MODE_LO + 16'($urandom_range(16'h1FFF));
        end
        else if (pick < 83)
        begin
            op = OP_READ;
            while ((addr >= ROM_WIN_LO && addr <= ROM_WIN_HI)
                   || (addr >= RAM_WIN_LO && addr <= RAM_WIN_HI))
                addr = 16'($urandom_range(16'hFFFF));
        end
        else if (pick < 90)
        begin
            op = OP_WRITE;
            while ((addr >= ROM_LOW_LO && addr <= MODE_HI)
                   || (addr >= RAM_WIN_LO && addr <= RAM_WIN_HI))
                addr = 16'($urandom_range(16'hFFFF));
        end
        add_access(op, addr, data, en);
    endtask

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.operation = OP_READ;
        req_ch.address = '0;
        req_ch.write_data = '0;
        req_ch.ext_ram_enabled = 1'b0;
        rsp_ch.ready = 1'b0;
        plan_regs = '{rom_bank: 7'd1, ram_bank: '0, mode: MODE_ROM};
        dut_regs = plan_regs;

        // ROM window edges and reads that go to the base memory.
        add_access(OP_READ,  16'h4000, 8'h00, 1'b0);
        add_access(OP_READ,  16'h7FFF, 8'hFF, 1'b1);
        add_access(OP_READ,  16'h0000, 8'h00, 1'b0);
        add_access(OP_READ,  16'hFFFF, 8'hFF, 1'b1);
        add_access(OP_READ,  16'h3FFF, 8'h00, 1'b0);
        add_access(OP_READ,  16'h8000, 8'h00, 1'b1);
        // A zero byte selects bank one; a nonzero byte with zero low bits selects zero.
        add_access(OP_WRITE, 16'h2000, 8'h00, 1'b0);
        add_access(OP_READ,  16'h4000, 8'h00, 1'b0);
        add_access(OP_WRITE, 16'h3FFF, 8'h20, 1'b0);
        add_access(OP_READ,  16'h5000, 8'h00, 1'b0);
        // Highest ROM bank gives the top cartridge address.
        add_access(OP_WRITE, 16'h4000, 8'hFF, 1'b0);
        add_access(OP_WRITE, 16'h2000, 8'h1F, 1'b0);
        add_access(OP_READ,  16'h7FFF, 8'h00, 1'b0);
        // RAM writes with and without enable; a disabled read still returns the store.
        add_access(OP_WRITE, 16'hA000, 8'hAA, 1'b1);
        add_access(OP_WRITE, 16'hBFFF, 8'h55, 1'b1);
        add_access(OP_WRITE, 16'hA000, 8'h11, 1'b0);
        add_access(OP_READ,  16'hA000, 8'h00, 1'b0);
        // RAM banking mode and the last RAM bank, then ROM banking mode and base memory writes.
        add_access(OP_WRITE, 16'h6000, 8'h01, 1'b0);
        add_access(OP_WRITE, 16'h5FFF, 8'h03, 1'b0);
        add_access(OP_WRITE, 16'hBFFF, 8'hFF, 1'b1);
        add_access(OP_READ,  16'hBFFF, 8'h00, 1'b1);
        add_access(OP_WRITE, 16'h7FFF, 8'hFE, 1'b1);
        add_access(OP_WRITE, 16'h0000, 8'hFF, 1'b1);
        add_access(OP_WRITE, 16'hFFFF, 8'h00, 1'b1);
        add_access(OP_WRITE, 16'h8000, 8'h5A, 1'b1);

        for (int i = 0; i < RANDOM_ITEMS; i++)
            add_random_access();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_accesses.size() != 0 || expected_responses.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_responses.size() == 0)
            $display("** cartridge_bank_controller: PASSED **");
        else
            $display("** cartridge_bank_controller: FAILED **");
        $finish;
    end

    // Request driver: holds an offered item until it is taken, idles now and then.
    always @(negedge clk)
    begin : access_driver
        bus_access_t head;
        logic        offer;
        if (req_fired)
            void'(pending_accesses.pop_front());
        if (!(req_ch.valid && !req_fired))
        begin
            offer = rst_n && pending_accesses.size() != 0
                    && ((accepted_accesses >= QUIET_FROM && accepted_accesses < QUIET_TO)
                        || $urandom_range(99) >= IDLE_PERCENT);
            req_ch.valid <= offer;
            if (offer)
            begin
                head = pending_accesses[0];
                req_ch.operation <= head.op;
                req_ch.address <= head.addr;
                req_ch.write_data <= head.data;
                req_ch.ext_ram_enabled <= head.en;
            end
        end
    end

    // Response sink, with one long hold-off that lets the block fill up.
    always @(negedge clk)
    begin
        if (hold_off_left != 0)
        begin
            hold_off_left <= hold_off_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (!hold_off_done && accepted_accesses >= HOLD_OFF_AT)
        begin
            hold_off_left <= HOLD_OFF_LEN - 1;
            hold_off_done <= 1'b1;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= rst_n
                            && ((accepted_accesses >= QUIET_FROM && accepted_accesses < QUIET_TO)
                                || $urandom_range(99) >= IDLE_PERCENT);
    end

    task automatic report_field(input string name, input int unsigned exp_val,
            input int unsigned act_val);
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, name, exp_val, act_val);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : response_monitor
        bus_access_t           acc;
        bus_response_t         exp_rsp;
        cbc_kind_t             kind;
        logic [ROM_ADDR_W-1:0] rom_addr;
        int unsigned           idx;
        logic                  wr;
        req_fired <= rst_n && req_ch.valid && req_ch.ready;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            acc = '{op: req_ch.operation, addr: req_ch.address,
                    data: req_ch.write_data, en: req_ch.ext_ram_enabled};
            kind = decode_access(acc, dut_regs, rom_addr, idx, wr);
            if (wr)
                ram_image[idx] = acc.data;
            exp_rsp.kind = kind;
            exp_rsp.rdata = (kind == KIND_RAM) ? ram_image[idx] : '0;
            exp_rsp.raddr = rom_addr;
            expected_responses.push_back(exp_rsp);
            accepted_accesses++;
        end
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_responses.size() == 0)
            begin
                $display("%0t ns: response item with no access pending, %s 0x%0h",
                         $time, "expected none, actual kind", rsp_ch.access_kind);
                mismatches++;
            end
            else
            begin
                exp_rsp = expected_responses.pop_front();
                if (rsp_ch.access_kind !== exp_rsp.kind)
                    report_field("access_kind", exp_rsp.kind, rsp_ch.access_kind);
                if (rsp_ch.read_data !== exp_rsp.rdata)
                    report_field("read_data", exp_rsp.rdata, rsp_ch.read_data);
                if (rsp_ch.rom_address !== exp_rsp.raddr)
                    report_field("rom_address", exp_rsp.raddr, rsp_ch.rom_address);
            end
        end
    end

    // Ends the run when neither side has moved an item for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t ns: no item moved for %0d cycles", $time, STALL_LIMIT);
                $display("** cartridge_bank_controller: FAILED **");
                $finish;
            end
        end
    end

endmodule
